/* rtl/ptt_pkg.sv */
// Shared types and constants for the proximity tap trigger.
`default_nettype none

package ptt_pkg;

    localparam int ENTRIES_DEF = 3;

    localparam int ADDR_W     = 48;
    localparam int SCORE_W    = 8;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCORE_W-1:0] SCORE_NONE = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 3'd5;

    localparam logic              RST_ENABLE    = 1'b1;
    localparam logic signed [7:0] RST_THRESHOLD = -8'sd35;
    localparam logic [6:0]        RST_STEP      = 7'd2;
    localparam logic [7:0]        RST_CEILING   = 8'd20;
    localparam logic [6:0]        RST_TRIGGER   = 7'd14;
    localparam logic [15:0]       RST_HOLDOFF   = 16'd30;

    typedef struct packed {
        logic capture;
        logic search;
        logic commit;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/ptt_ctrl.sv */
// Controller state machine: handshakes, sequencing and output word valid.
`default_nettype none

module ptt_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output ptt_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FIND  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_APPLY) && out_free));
    assign accept   = in_valid && !in_stall;

    assign cmd.capture = accept;
    assign cmd.search  = (state_reg == ST_FIND);
    assign cmd.commit  = (state_reg == ST_APPLY) && out_free;

    assign out_valid_next = cmd.commit || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = accept ? ST_FIND : ST_IDLE;
            end
            ST_FIND:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!out_free)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    state_next = accept ? ST_FIND : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ptt_datapath.sv */
// Datapath: config registers, sender table, search, score update and result word.
`default_nettype none

module ptt_datapath #(
    parameter int ENTRIES = ptt_pkg::ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ptt_pkg::cmd_t                     cmd,
    input  wire logic                              cfg_write,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ptt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              func,
    input  wire logic [ptt_pkg::ADDR_W-1:0]        sender_address,
    input  wire logic signed [7:0]                 strength,
    input  wire logic                              tap_flag,
    output logic                                   toggle,
    output logic                                   holdoff_active
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEAVES = 1 << IDX_W;

    // configuration
    logic              enable_reg;
    logic signed [7:0] threshold_reg;
    logic [6:0]        step_reg;
    logic [7:0]        ceiling_reg;
    logic [6:0]        trigger_reg;
    logic [15:0]       holdoff_ticks_reg;

    // captured word
    logic                          func_reg;
    logic [ptt_pkg::ADDR_W-1:0]    addr_reg;
    logic signed [7:0]             strength_reg;
    logic                          tap_reg;

    // search results
    logic [IDX_W-1:0] sel_reg;
    logic             found_reg;
    logic             pass_reg;

    // table state
    logic [ptt_pkg::ADDR_W-1:0]  entry_addr_reg  [ENTRIES];
    logic [ptt_pkg::ADDR_W-1:0]  entry_addr_next [ENTRIES];
    logic [ptt_pkg::SCORE_W-1:0] entry_score_reg [ENTRIES];
    logic [ptt_pkg::SCORE_W-1:0] entry_score_next[ENTRIES];
    logic [ptt_pkg::HOLD_W-1:0]  holdoff_reg;
    logic [ptt_pkg::HOLD_W-1:0]  holdoff_next;

    logic toggle_reg;
    logic toggle_next;
    logic holdoff_active_reg;

    // search logic
    logic [ENTRIES-1:0]           hit;
    logic                         any_hit;
    logic [IDX_W-1:0]             hit_idx;
    logic [ptt_pkg::SCORE_W-1:0]  leaf_score [LEAVES];
    logic [IDX_W-1:0]             leaf_idx   [LEAVES];
    logic [ptt_pkg::SCORE_W-1:0]  lvl_score  [IDX_W+1][LEAVES];
    logic [IDX_W-1:0]             lvl_idx    [IDX_W+1][LEAVES];

    // update logic
    logic [ptt_pkg::SCORE_W-1:0]  prev_score;
    logic [ptt_pkg::SCORE_W:0]    sum_score;
    logic [ptt_pkg::SCORE_W-1:0]  new_score;
    logic                         fire;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_hit
            assign hit[g] = (entry_addr_reg[g] == addr_reg);
        end
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < ENTRIES)
            begin : g_real
                assign leaf_score[g] = entry_score_reg[g];
            end
            else
            begin : g_pad
                assign leaf_score[g] = ptt_pkg::SCORE_NONE;
            end
            assign leaf_idx[g] = IDX_W'(g);
        end
    endgenerate

    assign any_hit = |hit;

    always_comb
    begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    // lowest-score tree, ties go to the lower index
    always_comb
    begin
        for (int l = 0; l <= IDX_W; l++)
        begin
            for (int k = 0; k < LEAVES; k++)
            begin
                lvl_score[l][k] = ptt_pkg::SCORE_NONE;
                lvl_idx[l][k]   = '0;
            end
        end
        for (int k = 0; k < LEAVES; k++)
        begin
            lvl_score[0][k] = leaf_score[k];
            lvl_idx[0][k]   = leaf_idx[k];
        end
        for (int l = 0; l < IDX_W; l++)
        begin
            for (int k = 0; k < (LEAVES >> (l + 1)); k++)
            begin
                if (lvl_score[l][2*k+1] < lvl_score[l][2*k])
                begin
                    lvl_score[l+1][k] = lvl_score[l][2*k+1];
                    lvl_idx[l+1][k]   = lvl_idx[l][2*k+1];
                end
                else
                begin
                    lvl_score[l+1][k] = lvl_score[l][2*k];
                    lvl_idx[l+1][k]   = lvl_idx[l][2*k];
                end
            end
        end
    end

    always_comb
    begin
        prev_score = found_reg ? entry_score_reg[sel_reg] : '0;
        sum_score  = {1'b0, prev_score} + {2'b00, step_reg};
        new_score  = (sum_score > {1'b0, ceiling_reg}) ? ceiling_reg
                                                       : sum_score[ptt_pkg::SCORE_W-1:0];
        fire       = (prev_score <= {1'b0, trigger_reg}) && (new_score > {1'b0, trigger_reg});
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            entry_addr_next[i]  = entry_addr_reg[i];
            entry_score_next[i] = entry_score_reg[i];
        end
        holdoff_next = holdoff_reg;
        toggle_next  = 1'b0;
        if (func_reg)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (entry_score_reg[i] != '0)
                begin
                    entry_score_next[i] = entry_score_reg[i] - 1'b1;
                end
            end
            if (holdoff_reg != '0)
            begin
                holdoff_next = holdoff_reg - 1'b1;
            end
        end
        else if (pass_reg)
        begin
            if (!found_reg)
            begin
                entry_addr_next[sel_reg]  = addr_reg;
                entry_score_next[sel_reg] = '0;
            end
            if (holdoff_reg == '0)
            begin
                entry_score_next[sel_reg] = new_score;
                if (fire)
                begin
                    holdoff_next = holdoff_ticks_reg;
                    toggle_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= ptt_pkg::RST_ENABLE;
            threshold_reg     <= ptt_pkg::RST_THRESHOLD;
            step_reg          <= ptt_pkg::RST_STEP;
            ceiling_reg       <= ptt_pkg::RST_CEILING;
            trigger_reg       <= ptt_pkg::RST_TRIGGER;
            holdoff_ticks_reg <= ptt_pkg::RST_HOLDOFF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ptt_pkg::CFG_ENABLE:    enable_reg        <= cfg_data[0];
                ptt_pkg::CFG_THRESHOLD: threshold_reg     <= cfg_data[7:0];
                ptt_pkg::CFG_STEP:      step_reg          <= cfg_data[6:0];
                ptt_pkg::CFG_CEILING:   ceiling_reg       <= cfg_data[7:0];
                ptt_pkg::CFG_TRIGGER:   trigger_reg       <= cfg_data[6:0];
                ptt_pkg::CFG_HOLDOFF:   holdoff_ticks_reg <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= func;
            addr_reg     <= sender_address;
            strength_reg <= strength;
            tap_reg      <= tap_flag;
        end
        if (cmd.search)
        begin
            sel_reg   <= any_hit ? hit_idx : lvl_idx[IDX_W][0];
            found_reg <= any_hit;
            pass_reg  <= enable_reg && tap_reg && (strength_reg >= threshold_reg);
        end
        if (cmd.commit)
        begin
            toggle_reg         <= toggle_next;
            holdoff_active_reg <= (holdoff_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_addr_reg[i]  <= '0;
                entry_score_reg[i] <= '0;
            end
            holdoff_reg <= '0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_addr_reg[i]  <= entry_addr_next[i];
                entry_score_reg[i] <= entry_score_next[i];
            end
            holdoff_reg <= holdoff_next;
        end
    end

    assign toggle         = toggle_reg;
    assign holdoff_active = holdoff_active_reg;

endmodule

`default_nettype wire

/* rtl/proximity_tap_trigger.sv */
// Top level of the proximity tap trigger: controller plus datapath.
//
// Input words carry func (0 beacon, 1 tick), sender_address, strength and
// tap_flag; each is taken when in_valid is high and in_stall is low.
// Every input word yields exactly one output word (toggle, holdoff_active),
// taken when out_valid is high and out_stall is low.
// After input accept the table search runs in the FIND state, then the score
// update and result register load in APPLY; a new word is accepted only when
// idle or during that update step, so this search/update sequence sets throughput.
// A finished word sits in the output register while the next input word is
// accepted and searched; if out_stall holds, the block waits in the update
// step and stalls its input until the output register frees up.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// Reset clears the sender table, scores and hold-off counter, restores the
// register defaults and leaves both channels empty.
`default_nettype none

module proximity_tap_trigger #(
    parameter int ENTRIES = ptt_pkg::ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              func,
    input  wire logic [ptt_pkg::ADDR_W-1:0]        sender_address,
    input  wire logic signed [7:0]                 strength,
    input  wire logic                              tap_flag,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   toggle,
    output logic                                   holdoff_active,
    input  wire logic                              cfg_write,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ptt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ptt_pkg::cmd_t cmd;

    ptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    ptt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .sender_address (sender_address),
        .strength       (strength),
        .tap_flag       (tap_flag),
        .toggle         (toggle),
        .holdoff_active (holdoff_active)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && cmd.search))
        else $error("input not stalled during search");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("result register overwritten while stalled");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !cmd.commit) |=> !out_valid)
        else $error("output word repeated");

    a_commit_before_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search |=> !cmd.capture || cmd.commit)
        else $error("input accepted before update");
`endif

endmodule

`default_nettype wire

/* sim/proximity_tap_trigger_tb.sv */
// Self-checking testbench for proximity_tap_trigger: directed and random words.
`timescale 1ns / 100ps

module proximity_tap_trigger_tb;

    localparam int ENTRIES      = ptt_pkg::ENTRIES_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 65;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES   = 8;

    localparam logic FUNC_BEACON = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // indexes with no register behind them
    localparam logic [ptt_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [ptt_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic                           func;
        logic [ptt_pkg::ADDR_W-1:0]     sender_address;
        logic signed [7:0]              strength;
        logic                           tap_flag;
    } air_word_t;

    typedef struct {
        logic toggle;
        logic holdoff_active;
    } trig_result_t;

    typedef struct {
        logic              enable;
        logic signed [7:0] threshold;
        logic [6:0]        step;
        logic [7:0]        ceiling;
        logic [6:0]        trigger;
        logic [15:0]       holdoff;
    } cfg_set_t;

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               func = FUNC_BEACON;
    logic [ptt_pkg::ADDR_W-1:0]         sender_address = '0;
    logic signed [7:0]                  strength = '0;
    logic                               tap_flag = 1'b0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               toggle;
    logic                               holdoff_active;
    logic                               cfg_write = 1'b0;
    logic [ptt_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [ptt_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // scoring model state
    logic [ptt_pkg::ADDR_W-1:0]  tbl_addr [ENTRIES] = '{default: '0};
    logic [ptt_pkg::SCORE_W-1:0] tbl_score [ENTRIES] = '{default: '0};
    logic [ptt_pkg::HOLD_W-1:0]  hold_cnt = '0;

    logic              reg_enable    = ptt_pkg::RST_ENABLE;
    logic signed [7:0] reg_threshold = ptt_pkg::RST_THRESHOLD;
    logic [6:0]        reg_step      = ptt_pkg::RST_STEP;
    logic [7:0]        reg_ceiling   = ptt_pkg::RST_CEILING;
    logic [6:0]        reg_trigger   = ptt_pkg::RST_TRIGGER;
    logic [15:0]       reg_holdoff   = ptt_pkg::RST_HOLDOFF;

    trig_result_t               outcome_q [$];
    logic [ptt_pkg::ADDR_W-1:0] addr_pool [5];

    int fail_count  = 0;
    int cycle_count = 0;
    int tx_run      = 0;
    int rx_run      = 0;
    int rx_wait     = 0;

    proximity_tap_trigger dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .sender_address (sender_address),
        .strength       (strength),
        .tap_flag       (tap_flag),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .toggle         (toggle),
        .holdoff_active (holdoff_active),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic trig_result_t predict_trigger(input air_word_t w);
        trig_result_t r;
        int           sel;
        bit           hit;
        logic [7:0]   lowest;
        int           prev;
        int           nxt;
        r.toggle = 1'b0;
        sel = 0;
        hit = 1'b0;
        lowest = ptt_pkg::SCORE_NONE;
        if (w.func == FUNC_TICK)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (tbl_score[i] != 0)
                    tbl_score[i]--;
            if (hold_cnt != 0)
                hold_cnt--;
        end
        else if (reg_enable && w.strength >= reg_threshold && w.tap_flag)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!hit)
                begin
                    if (tbl_addr[i] == w.sender_address)
                    begin
                        sel = i;
                        hit = 1'b1;
                    end
                    else if (tbl_score[i] < lowest)
                    begin
                        lowest = tbl_score[i];
                        sel = i;
                    end
                end
            end
            if (!hit)
            begin
                tbl_addr[sel] = w.sender_address;
                tbl_score[sel] = '0;
            end
            if (hold_cnt == 0)
            begin
                prev = tbl_score[sel];
                nxt = prev + reg_step;
                if (nxt > reg_ceiling)
                    nxt = reg_ceiling;
                tbl_score[sel] = nxt[7:0];
                if (prev <= reg_trigger && nxt > reg_trigger)
                begin
                    hold_cnt = reg_holdoff;
                    r.toggle = 1'b1;
                end
            end
        end
        r.holdoff_active = (hold_cnt != 0);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin : result_check
        trig_result_t want;
        if (out_valid && !out_stall)
        begin
            if (outcome_q.size() == 0)
                note_failure($sformatf("unexpected word: toggle=%0b holdoff_active=%0b",
                                       toggle, holdoff_active));
            else
            begin
                want = outcome_q.pop_front();
                if (toggle !== want.toggle || holdoff_active !== want.holdoff_active)
                    note_failure($sformatf(
                        "mismatch: expected toggle=%0b holdoff_active=%0b, got %0b %0b",
                        want.toggle, want.holdoff_active, toggle, holdoff_active));
            end
            rx_wait = draw_gap(rx_run);
        end
        else if (rx_wait > 0 && (out_valid || $urandom_range(0, 1) == 1))
            rx_wait--;
        out_stall <= (rx_wait != 0);
    end

    task automatic send_word(input air_word_t w);
        int gap;
        gap = draw_gap(tx_run);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= w.func;
        sender_address <= w.sender_address;
        strength       <= w.strength;
        tap_flag       <= w.tap_flag;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        outcome_q.push_back(predict_trigger(w));
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ptt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptt_pkg::CFG_DATA_W-1:0] value, input int width);
        logic [ptt_pkg::CFG_DATA_W-1:0] mask;
        logic [ptt_pkg::CFG_DATA_W-1:0] data;
        mask = (width >= ptt_pkg::CFG_DATA_W) ? '1
                                              : ptt_pkg::CFG_DATA_W'((1 << width) - 1);
        data = ptt_pkg::CFG_DATA_W'($urandom);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (data & ~mask) | (value & mask);
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_set_t s);
        write_reg(ptt_pkg::CFG_ENABLE, ptt_pkg::CFG_DATA_W'(s.enable), 1);
        write_reg(ptt_pkg::CFG_THRESHOLD, ptt_pkg::CFG_DATA_W'(s.threshold), 8);
        write_reg(ptt_pkg::CFG_STEP, ptt_pkg::CFG_DATA_W'(s.step), 7);
        write_reg(ptt_pkg::CFG_CEILING, ptt_pkg::CFG_DATA_W'(s.ceiling), 8);
        write_reg(ptt_pkg::CFG_TRIGGER, ptt_pkg::CFG_DATA_W'(s.trigger), 7);
        write_reg(ptt_pkg::CFG_HOLDOFF, ptt_pkg::CFG_DATA_W'(s.holdoff), 16);
        // unused indexes must leave every register alone
        write_reg(CFG_SPARE_A, ptt_pkg::CFG_DATA_W'($urandom), ptt_pkg::CFG_DATA_W);
        write_reg(CFG_SPARE_B, ptt_pkg::CFG_DATA_W'($urandom), ptt_pkg::CFG_DATA_W);
        cfg_write <= 1'b0;
        @(posedge clk);
        reg_enable    = s.enable;
        reg_threshold = s.threshold;
        reg_step      = s.step;
        reg_ceiling   = s.ceiling;
        reg_trigger   = s.trigger;
        reg_holdoff   = s.holdoff;
    endtask

    function automatic cfg_set_t make_settings(input logic en, input logic signed [7:0] thr,
                                               input logic [6:0] step, input logic [7:0] ceil,
                                               input logic [6:0] trig, input logic [15:0] hold);
        cfg_set_t s;
        s.enable    = en;
        s.threshold = thr;
        s.step      = step;
        s.ceiling   = ceil;
        s.trigger   = trig;
        s.holdoff   = hold;
        return s;
    endfunction

    function automatic air_word_t beacon(input logic [ptt_pkg::ADDR_W-1:0] addr,
                                         input logic signed [7:0] str, input logic tap);
        air_word_t w;
        w.func           = FUNC_BEACON;
        w.sender_address = addr;
        w.strength       = str;
        w.tap_flag       = tap;
        return w;
    endfunction

    function automatic air_word_t tick();
        air_word_t w;
        w.func           = FUNC_TICK;
        w.sender_address = ptt_pkg::ADDR_W'({$urandom, $urandom});
        w.strength       = 8'($urandom);
        w.tap_flag       = 1'($urandom);
        return w;
    endfunction

    function automatic air_word_t random_word();
        air_word_t w;
        int        thr;
        thr = reg_threshold;
        w.func = ($urandom_range(0, 99) < 30) ? FUNC_TICK : FUNC_BEACON;
        if ($urandom_range(0, 9) == 0)
            w.sender_address = ptt_pkg::ADDR_W'({$urandom, $urandom});
        else
            w.sender_address = addr_pool[$urandom_range(0, 4)];
        if ($urandom_range(0, 99) < 85)
            w.strength = 8'(thr + int'($urandom_range(0, 127 - thr)));
        else
            w.strength = 8'($urandom);
        w.tap_flag = ($urandom_range(0, 9) != 0);
        return w;
    endfunction

    // defaults straight out of reset, zero address, strength and tap-flag gating
    task automatic test_reset_values();
        send_word(beacon(48'h0, -8'sd35, 1'b1));
        send_word(beacon(48'hFFFF_FFFF_FFFF, -8'sd36, 1'b1));
        send_word(beacon(48'hFFFF_FFFF_FFFF, 8'sd127, 1'b0));
        send_word(beacon(48'hFFFF_FFFF_FFFF, 8'sd127, 1'b1));
        send_word(tick());
    endtask

    // saturate all entries at 255, then a new sender must land in entry 0
    task automatic test_full_scores();
        logic [ptt_pkg::ADDR_W-1:0] senders [3];
        senders = '{48'h8000_0000_0000, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA};
        wait_until_drained();
        load_settings(make_settings(1'b1, -8'sd128, 7'd127, 8'd255, 7'd127, 16'd0));
        foreach (senders[i])
            repeat (3) send_word(beacon(senders[i], -8'sd128, 1'b1));
        send_word(beacon(48'h0000_0000_0001, -8'sd128, 1'b1));
    endtask

    task automatic test_ceiling_zero();
        wait_until_drained();
        load_settings(make_settings(1'b1, -8'sd128, 7'd127, 8'd0, 7'd0, 16'd0));
        send_word(beacon(48'h0000_0000_0001, 8'sd5, 1'b1));
        send_word(beacon(48'h8000_0000_0000, 8'sd5, 1'b1));
    endtask

    // trigger, replacement while held off, hold-off expiry
    task automatic test_holdoff();
        wait_until_drained();
        load_settings(make_settings(1'b1, -8'sd35, 7'd8, 8'd20, 7'd14, 16'd2));
        send_word(beacon(48'h0000_0000_0001, -8'sd20, 1'b1));
        send_word(beacon(48'h0000_0000_0001, -8'sd20, 1'b1));
        send_word(beacon(48'h0000_0000_0002, -8'sd20, 1'b1));
        send_word(tick());
        send_word(tick());
        send_word(beacon(48'h0000_0000_0002, -8'sd20, 1'b1));
    endtask

    task automatic test_disabled();
        wait_until_drained();
        load_settings(make_settings(1'b0, -8'sd35, 7'd8, 8'd20, 7'd14, 16'd2));
        send_word(beacon(48'h0000_0000_0001, 8'sd100, 1'b1));
        send_word(tick());
    endtask

    function automatic cfg_set_t phase_settings(input int phase);
        cfg_set_t s;
        if (phase == 0)
            s = make_settings(1'b1, -8'sd128, 7'd1, 8'd1, 7'd0, 16'd0);
        else if (phase == RANDOM_PHASES - 1)
            s = make_settings(1'b1, 8'sd127, 7'd127, 8'd128, 7'd127, 16'hFFFF);
        else
        begin
            s.enable    = (phase != 3) || ($urandom_range(0, 3) != 0);
            s.threshold = 8'($urandom);
            s.step      = 7'($urandom_range(1, 8));
            s.ceiling   = 8'($urandom_range(4, 40));
            s.trigger   = 7'($urandom_range(0, s.ceiling - 1));
            s.holdoff   = 16'($urandom_range(0, 12));
        end
        return s;
    endfunction

    task automatic test_random_traffic();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 5; i++)
            addr_pool[i] = ptt_pkg::ADDR_W'({$urandom, $urandom});
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_until_drained();
            load_settings(phase_settings(phase));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (phase == 2 && n == PHASE_WORDS / 2)
                    wait_until_drained();
                send_word(random_word());
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_full_scores();
        test_ceiling_zero();
        test_holdoff();
        test_disabled();
        test_random_traffic();
        wait_until_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* proximity_tap_trigger.f */
rtl/ptt_pkg.sv
rtl/ptt_ctrl.sv
rtl/ptt_datapath.sv
rtl/proximity_tap_trigger.sv
sim/proximity_tap_trigger_tb.sv
